>>> design/raster_to_tile_swizzle_top_defines.svh
// Assertion macros shared by the swizzle RTL.
`ifndef RASTER_TO_TILE_SWIZZLE_TOP_DEFINES_SVH
`define RASTER_TO_TILE_SWIZZLE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define RTTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk outside reset.
`define RTTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rtts_pkg.sv
`default_nettype none

package rtts_pkg;

  localparam int CFG_W       = 10;   // size register width
  localparam int PIX_W       = 16;   // input pixel word
  localparam int OFF_W       = 18;   // byte offset width
  localparam int BYTE_W      = 8;
  localparam int NIB_W       = 4;
  localparam int TILE_SHIFT  = 3;    // 8x8 tiles
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;
  localparam int OUT_TDATA_W = 32;   // offset + byte, padded to bytes

  // register index, paddr[3:2]
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_DEPTH_MODE   = 2'd2
  } reg_idx_t;

  typedef enum logic {
    DEPTH_4BPP = 1'b0,
    DEPTH_8BPP = 1'b1
  } depth_t;

endpackage

`default_nettype wire

>>> design/raster_to_tile_swizzle_top.sv
`default_nettype none
// Raster to 8x8 tile swizzle. Pixels enter one per item in raster order on the
// in_ stream; each complete 8x8 tile of the image is written out as bytes with
// their offset in the tiled destination (tiles row-major, bytes row-major in a
// tile). 8bpp mode emits the low byte of every pixel (64-byte tiles); 4bpp
// mode holds the low nibble of the even pixel and emits one packed byte on the
// odd pixel, left pixel in the low nibble (32-byte tiles). Pixels in trailing
// columns/rows that do not fill a tile emit nothing. tlast flags the last byte
// of the image; the position counters wrap after every image. Throughput is
// one pixel per clock: the offset math (one small multiply and an add) sits
// between the position counters and the output register, so each item is
// registered once and the input stalls only when the output register is
// full and not being taken. Sizes of 0 act as 1; sizes above MAX_WIDTH or
// MAX_HEIGHT saturate. Write the config registers only while idle.
module raster_to_tile_swizzle_top
  import rtts_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input pixel stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [PIX_W-1:0]       in_tdata,     // [15:0] pixel_value
  // tiled byte stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,    // [17:0] byte_offset, [25:18] byte_value
  output logic                        out_tlast,    // image_done
  // config port
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [PADDR_W-1:0]     cfg_paddr,
  input  wire logic [PDATA_W-1:0]     cfg_pwdata,
  output logic [PDATA_W-1:0]          cfg_prdata,
  output logic                        cfg_pready
);

`include "raster_to_tile_swizzle_top_defines.svh"

  // counter widths and size-compare widths
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WSW = (CFG_W > XW + 1) ? CFG_W : XW + 1;
  localparam int HSW = (CFG_W > YW + 1) ? CFG_W : YW + 1;
  localparam int TW  = YW + WSW;          // tile index width
  localparam int FW  = TW + 6;            // full offset before masking

  // ---------------- config registers ----------------
  logic [CFG_W-1:0] width_r,  width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic             depth_r,  depth_nxt;
  logic             cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    depth_nxt  = depth_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_paddr[3:2]))
        REG_IMAGE_WIDTH:  width_nxt  = cfg_pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: height_nxt = cfg_pwdata[CFG_W-1:0];
        REG_DEPTH_MODE:   depth_nxt  = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[3:2]))
      REG_IMAGE_WIDTH:  cfg_prdata = PDATA_W'(width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = PDATA_W'(height_r);
      REG_DEPTH_MODE:   cfg_prdata = PDATA_W'(depth_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(8);
      height_r <= CFG_W'(8);
      depth_r  <= DEPTH_4BPP;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
    end
  end

  // effective sizes: 0 acts as 1, saturate at the maximum
  logic [WSW-1:0] w_eff;
  logic [HSW-1:0] h_eff;

  always_comb begin
    if (width_r == '0)                        w_eff = WSW'(1);
    else if (WSW'(width_r) > WSW'(MAX_WIDTH)) w_eff = WSW'(MAX_WIDTH);
    else                                      w_eff = WSW'(width_r);
    if (height_r == '0)                         h_eff = HSW'(1);
    else if (HSW'(height_r) > HSW'(MAX_HEIGHT)) h_eff = HSW'(MAX_HEIGHT);
    else                                        h_eff = HSW'(height_r);
  end

  // ---------------- position counters ----------------
  logic [XW-1:0]    col_r, col_nxt;
  logic [YW-1:0]    row_r, row_nxt;
  logic [NIB_W-1:0] nib_r, nib_nxt;
  logic             in_fire;

  logic [WSW-1:0] w_full;      // width rounded down to whole tiles
  logic [HSW-1:0] h_full;
  logic [WSW-1:0] tiles_x;
  logic [WSW-1:0] col_x;
  logic [HSW-1:0] row_y;
  logic [WSW-1:0] col_inc;
  logic [HSW-1:0] row_inc;
  logic           in_tile;
  logic           last_px;
  logic [2:0]     sub_c;
  logic [2:0]     sub_r;
  logic [TW-1:0]  tile_idx;
  logic [FW-1:0]  off_8bpp;
  logic [FW-1:0]  off_4bpp;

  assign in_fire = in_tvalid & in_tready;

  assign w_full  = {w_eff[WSW-1:TILE_SHIFT], {TILE_SHIFT{1'b0}}};
  assign h_full  = {h_eff[HSW-1:TILE_SHIFT], {TILE_SHIFT{1'b0}}};
  assign tiles_x = w_eff >> TILE_SHIFT;
  assign col_x   = WSW'(col_r);
  assign row_y   = HSW'(row_r);
  assign col_inc = col_x + WSW'(1);
  assign row_inc = row_y + HSW'(1);
  assign sub_c   = col_r[2:0];
  assign sub_r   = row_r[2:0];

  assign in_tile = (col_x < w_full) && (row_y < h_full);
  assign last_px = (col_x == w_full - WSW'(1)) && (row_y == h_full - HSW'(1));

  // tile number = (y / 8) * tiles_x + x / 8
  assign tile_idx = TW'(row_r >> TILE_SHIFT) * TW'(tiles_x) + TW'(col_r >> TILE_SHIFT);
  assign off_8bpp = {tile_idx, sub_r, sub_c};
  assign off_4bpp = FW'({tile_idx, sub_r[2:0], sub_c[2:1]});

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    nib_nxt = nib_r;
    if (in_fire) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : YW'(row_inc);
      end else begin
        col_nxt = XW'(col_inc);
        if (row_y >= h_eff) row_nxt = '0;
      end
      // even pixel of a pair in 4bpp mode is held for the next one
      if (in_tile && depth_r == DEPTH_4BPP && !sub_c[0]) begin
        nib_nxt = in_tdata[NIB_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      nib_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      nib_r <= nib_nxt;
    end
  end

  // ---------------- output register ----------------
  logic              has_res;
  logic [OFF_W-1:0]  res_off;
  logic [BYTE_W-1:0] res_byte;

  logic              out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0]  out_off_r,   out_off_nxt;
  logic [BYTE_W-1:0] out_byte_r,  out_byte_nxt;
  logic              out_last_r,  out_last_nxt;
  logic              out_load;

  always_comb begin
    if (depth_r == DEPTH_8BPP) begin
      has_res  = in_tile;
      res_off  = off_8bpp[OFF_W-1:0];
      res_byte = in_tdata[BYTE_W-1:0];
    end else begin
      has_res  = in_tile & sub_c[0];
      res_off  = off_4bpp[OFF_W-1:0];
      res_byte = {in_tdata[NIB_W-1:0], nib_r};
    end
  end

  // a new item may enter whenever the output slot is free or draining
  assign out_load  = !out_valid_r || out_tready;
  assign in_tready = out_load;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_off_nxt   = out_off_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = in_fire & has_res;
      out_off_nxt   = res_off;
      out_byte_nxt  = res_byte;
      out_last_nxt  = last_px;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_off_r  <= out_off_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_byte_r, out_off_r});
  assign out_tlast  = out_last_r;

  // ---------------- checks ----------------
  // an empty output slot never blocks the input
  `RTTS_ASSERT_NOW(a_ready_when_empty, !out_valid_r, in_tready, "input stalled with empty output")
  // the last image byte is always the last byte of a tile (31 or 63)
  `RTTS_ASSERT_NOW(a_last_tile_end, out_valid_r && out_last_r, out_off_r[4:0] == 5'h1f,
                   "image end not on a tile end")
  // after a pixel step the column lies inside the current width
  `RTTS_ASSERT_NEXT(a_col_in_range, in_fire && !cfg_we, col_x < w_eff,
                    "column counter beyond width")

endmodule

`default_nettype wire
